FILE: design/base_relocation_block_parser_defines.svh
// Assertion macros shared by the base-relocation parser RTL.
`ifndef BASE_RELOCATION_BLOCK_PARSER_DEFINES_SVH
`define BASE_RELOCATION_BLOCK_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define BRBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define BRBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/brbp_pkg.sv
// Shared types and constants for the base-relocation parser.
package brbp_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_DATA    = 2'd1,
        OP_EXHAUST = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ENTRY   = 2'd0,
        ST_SUCCESS = 2'd1,
        ST_CORRUPT = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned WORD_W       = 16;
    localparam int unsigned OFFSET_W     = 12;
    localparam int unsigned TYPE_W       = WORD_W - OFFSET_W;
    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned WORD_BYTES   = 2;

    // Result buffer sizing: two pushes per cycle, one pop
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    // Accept only while a staged and a newly accepted transaction both fit
    localparam int unsigned FIFO_ACCEPT_MAX = FIFO_DEPTH - 4;

    // APB register indexes (word address)
    localparam logic REG_DIR_BASE  = 1'b0;
    localparam logic REG_DIR_BYTES = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] entry_address;
        status_t           status;
        logic              last;
    } result_t;

    // Results produced by one parser step
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

FILE: design/brbp_walker.sv
// Parser state and per-word decode: header assembly, entry filter, end checks.
module brbp_walker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_valid,
    input  brbp_pkg::opcode_t            step_opcode,
    input  logic [brbp_pkg::WORD_W-1:0]  step_word,
    input  logic [brbp_pkg::ADDR_W-1:0]  dir_base,
    input  logic [brbp_pkg::ADDR_W-1:0]  dir_bytes,
    output brbp_pkg::push_t              push
);
    import brbp_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_ENTRIES = 2'd2
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        hwi_reg, hwi_next;
    logic [ADDR_W-1:0] page_reg, page_next;
    logic [ADDR_W-1:0] bbytes_reg, bbytes_next;
    logic [ADDR_W-1:0] bcons_reg, bcons_next;
    logic [ADDR_W-1:0] dcons_reg, dcons_next;

    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] dcons_inc;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] bcons_inc;
    logic [ADDR_W-1:0] bbytes_hdr;
    logic              in_dir;
    logic              more_entries;
    logic              is_entry;
    result_t           entry_res;
    result_t           success_res;

    // Directory end and advanced positions (address is base plus bytes consumed)
    assign end_addr   = dir_base + dir_bytes;
    assign dcons_inc  = dcons_reg + ADDR_W'(WORD_BYTES);
    assign cur_addr   = dir_base + dcons_inc;
    assign bcons_inc  = bcons_reg + ADDR_W'(WORD_BYTES);
    assign bbytes_hdr = {step_word, bbytes_reg[WORD_W-1:0]};
    assign in_dir     = cur_addr < end_addr;
    assign is_entry   = step_word[WORD_W-1 -: TYPE_W] != '0;

    assign entry_res.entry_address = page_reg | {{(ADDR_W-OFFSET_W){1'b0}},
                                                 step_word[OFFSET_W-1:0]};
    assign entry_res.status        = ST_ENTRY;
    assign entry_res.last          = 1'b0;

    assign success_res.entry_address = '0;
    assign success_res.status        = ST_SUCCESS;
    assign success_res.last          = 1'b1;

    // Block continues with entries only while both counts allow
    assign more_entries = (phase_reg == PH_HEADER) ? (ADDR_W'(HEADER_BYTES) < bbytes_hdr)
                                                   : (bcons_inc < bbytes_reg);

    // Step decode
    always_comb
    begin
        phase_next  = phase_reg;
        hwi_next    = hwi_reg;
        page_next   = page_reg;
        bbytes_next = bbytes_reg;
        bcons_next  = bcons_reg;
        dcons_next  = dcons_reg;
        push        = '0;
        if (step_valid)
        begin
            case (step_opcode)
                OP_START:
                begin
                    if (dir_base == '0 || dir_bytes == '0)
                    begin
                        phase_next                = PH_IDLE;
                        push.push0                = 1'b1;
                        push.res0.entry_address   = '0;
                        push.res0.status          = ST_ABSENT;
                        push.res0.last            = 1'b1;
                    end
                    else
                    begin
                        dcons_next = '0;
                        bcons_next = '0;
                        if (dir_base < end_addr)
                        begin
                            phase_next = PH_HEADER;
                            hwi_next   = 2'd0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            push.push0 = 1'b1;
                            push.res0  = success_res;
                        end
                    end
                end
                OP_EXHAUST:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        phase_next              = PH_IDLE;
                        push.push0              = 1'b1;
                        push.res0.entry_address = '0;
                        push.res0.status        = ST_CORRUPT;
                        push.res0.last          = 1'b1;
                    end
                end
                OP_DATA:
                begin
                    if (phase_reg == PH_HEADER)
                    begin
                        dcons_next = dcons_inc;
                        case (hwi_reg)
                            2'd0:    page_next   = {{(ADDR_W-WORD_W){1'b0}}, step_word};
                            2'd1:    page_next   = {step_word, page_reg[WORD_W-1:0]};
                            2'd2:    bbytes_next = {{(ADDR_W-WORD_W){1'b0}}, step_word};
                            default: bbytes_next = bbytes_hdr;
                        endcase
                        if (hwi_reg != 2'd3)
                        begin
                            hwi_next = hwi_reg + 2'd1;
                        end
                        else
                        begin
                            hwi_next   = 2'd0;
                            bcons_next = ADDR_W'(HEADER_BYTES);
                            if (in_dir && more_entries)
                            begin
                                phase_next = PH_ENTRIES;
                            end
                            else if (in_dir)
                            begin
                                phase_next = PH_HEADER;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                push.push0 = 1'b1;
                                push.res0  = success_res;
                            end
                        end
                    end
                    else if (phase_reg == PH_ENTRIES)
                    begin
                        dcons_next = dcons_inc;
                        bcons_next = bcons_inc;
                        // Entry result comes first, success behind it
                        if (is_entry)
                        begin
                            push.push0 = 1'b1;
                            push.res0  = entry_res;
                        end
                        if (in_dir && more_entries)
                        begin
                            phase_next = PH_ENTRIES;
                        end
                        else if (in_dir)
                        begin
                            phase_next = PH_HEADER;
                            hwi_next   = 2'd0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            if (is_entry)
                            begin
                                push.push1 = 1'b1;
                                push.res1  = success_res;
                            end
                            else
                            begin
                                push.push0 = 1'b1;
                                push.res0  = success_res;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            hwi_reg    <= 2'd0;
            page_reg   <= '0;
            bbytes_reg <= '0;
            bcons_reg  <= '0;
            dcons_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hwi_reg    <= hwi_next;
            page_reg   <= page_next;
            bbytes_reg <= bbytes_next;
            bcons_reg  <= bcons_next;
            dcons_reg  <= dcons_next;
        end
    end

endmodule

FILE: design/brbp_result_fifo.sv
// Result buffer: up to two writes per cycle, one read per cycle.
module brbp_result_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  brbp_pkg::push_t                 push,
    input  logic                            pop,
    output brbp_pkg::result_t               head,
    output logic                            not_empty,
    output logic [brbp_pkg::FIFO_CNT_W-1:0] count
);
    import brbp_pkg::*;

    result_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic [FIFO_PTR_W-1:0]   wr_ptr_inc;
    logic                    do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign wr_ptr_inc = wr_ptr_reg + FIFO_PTR_W'(1);
    assign head       = mem[rd_ptr_reg];
    assign not_empty  = count_reg != '0;
    assign count      = count_reg;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.push0) + FIFO_PTR_W'(push.push1);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        count_next  = count_reg + FIFO_CNT_W'(push.push0) + FIFO_CNT_W'(push.push1)
                      - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes
    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            mem[wr_ptr_inc] <= push.res1;
        end
    end

endmodule

FILE: design/base_relocation_block_parser.sv
// Base-relocation directory parser top level: APB registers, input stage, result buffer.
// Path: an accepted transaction is registered in the input stage, and its results are written
// to the result buffer before they are offered on the result channel.
// Throughput: one transaction per cycle while results drain; set by the 8-entry result
// buffer, which takes new input only while it holds 4 or fewer results.
// Reset: rst_n (async, active low) clears registers, parser state and the buffer.
`include "base_relocation_block_parser_defines.svh"

module base_relocation_block_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic [brbp_pkg::WORD_W-1:0]  data_word,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [brbp_pkg::ADDR_W-1:0]  entry_address,
    output logic [1:0]                   status,
    output logic                         last
);
    import brbp_pkg::*;

    logic [ADDR_W-1:0]     dir_base_reg;
    logic [ADDR_W-1:0]     dir_bytes_reg;
    logic                  cfg_write;

    logic                  stage_valid_reg;
    opcode_t               stage_opcode_reg;
    logic [WORD_W-1:0]     stage_word_reg;

    push_t                 push;
    result_t               head;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] fifo_count;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_DIR_BYTES) ? dir_bytes_reg : dir_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_base_reg  <= '0;
            dir_bytes_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_DIR_BASE:  dir_base_reg  <= pwdata;
                REG_DIR_BYTES: dir_bytes_reg <= pwdata;
                default:       dir_base_reg  <= dir_base_reg;
            endcase
        end
    end

    // Input stage
    assign in_ready = fifo_count <= FIFO_CNT_W'(FIFO_ACCEPT_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= in_valid && in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_opcode_reg <= opcode_t'(opcode);
            stage_word_reg   <= data_word;
        end
    end

    brbp_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_valid  (stage_valid_reg),
        .step_opcode (stage_opcode_reg),
        .step_word   (stage_word_reg),
        .dir_base    (dir_base_reg),
        .dir_bytes   (dir_bytes_reg),
        .push        (push)
    );

    brbp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_ready),
        .head      (head),
        .not_empty (not_empty),
        .count     (fifo_count)
    );

    // Result channel
    assign out_valid     = not_empty;
    assign entry_address = head.entry_address;
    assign status        = head.status;
    assign last          = head.last;

    // Checks
    `BRBP_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_count <= FIFO_CNT_W'(FIFO_DEPTH), "result buffer overflow")
    `BRBP_ASSERT_NOW(a_push_order, push.push1, push.push0 && push.res0.status == ST_ENTRY, "second result without entry first")
    `BRBP_ASSERT_NOW(a_final_last, push.push0 && push.res0.status != ST_ENTRY, push.res0.last && !push.push1, "final status not marked last")
    `BRBP_ASSERT_NEXT(a_accept_stage, in_valid && in_ready, stage_valid_reg, "accepted transaction not staged")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the base-relocation directory parser.
module tb_top;
    import brbp_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned CALM_AT      = 1200;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [WORD_W-1:0] data_word;
    logic        out_valid;
    logic        out_ready;
    logic [ADDR_W-1:0] entry_address;
    logic [1:0]  status;
    logic        last;

    // walk state of the directory parser
    typedef enum logic [1:0] {
        WALK_IDLE    = 2'd0,
        WALK_HEADER  = 2'd1,
        WALK_ENTRIES = 2'd2
    } walk_t;

    // Predicts parser results from accepted transactions and matches them in order
    class reloc_scoreboard;
        logic [31:0] dir_base;
        logic [31:0] dir_bytes;
        walk_t       walk;
        logic [1:0]  hdr_idx;
        logic [31:0] page;
        logic [31:0] blk_bytes;
        logic [31:0] blk_used;
        logic [31:0] dir_used;
        result_t     due_results[$];
        int unsigned errors;

        function new();
            dir_base  = '0;
            dir_bytes = '0;
            walk      = WALK_IDLE;
            hdr_idx   = '0;
            page      = '0;
            blk_bytes = '0;
            blk_used  = '0;
            dir_used  = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_DIR_BASE)
                dir_base = value;
            else
                dir_bytes = value;
        endfunction

        // current address below end, both modulo 2^32
        function bit in_directory();
            logic [31:0] cur;
            logic [31:0] stop;
            cur  = dir_base + dir_used;
            stop = dir_base + dir_bytes;
            return cur < stop;
        endfunction

        function void push(logic [31:0] addr, status_t st, logic fin);
            result_t r;
            r.entry_address = addr;
            r.status        = st;
            r.last          = fin;
            due_results = {due_results, r};
        endfunction

        // pick next walk state; success once the directory is used up
        function void advance();
            if (walk == WALK_ENTRIES && in_directory() && blk_used < blk_bytes)
                return;
            if (in_directory()) begin
                walk    = WALK_HEADER;
                hdr_idx = '0;
            end
            else begin
                walk = WALK_IDLE;
                push('0, ST_SUCCESS, 1'b1);
            end
        endfunction

        function void take_word(opcode_t op, logic [15:0] w);
            if (op == OP_START) begin
                if (dir_base == 0 || dir_bytes == 0) begin
                    walk = WALK_IDLE;
                    push('0, ST_ABSENT, 1'b1);
                    return;
                end
                dir_used = '0;
                blk_used = '0;
                walk     = WALK_HEADER;
                advance();
                return;
            end
            if (op == OP_NONE || walk == WALK_IDLE)
                return;
            if (op == OP_EXHAUST) begin
                walk = WALK_IDLE;
                push('0, ST_CORRUPT, 1'b1);
                return;
            end
            dir_used = dir_used + 32'd2;
            // header: page low, page high, size low, size high
            if (walk == WALK_HEADER) begin
                case (hdr_idx)
                    2'd0: page = {16'h0, w};
                    2'd1: page = page | {w, 16'h0};
                    2'd2: blk_bytes = {16'h0, w};
                    default: blk_bytes = blk_bytes | {w, 16'h0};
                endcase
                if (hdr_idx < 2'd3) begin
                    hdr_idx = hdr_idx + 2'd1;
                    return;
                end
                hdr_idx  = '0;
                blk_used = 32'd8;
                walk     = WALK_ENTRIES;
                advance();
                return;
            end
            // entry: type zero is padding
            if (w[15:12] != 4'h0)
                push(page | {20'h0, w[11:0]}, ST_ENTRY, 1'b0);
            blk_used = blk_used + 32'd2;
            advance();
        endfunction

        function void match_result(logic [31:0] addr, logic [1:0] st, logic fin);
            result_t want;
            if (due_results.size() == 0) begin
                $error("unexpected result: entry_address %h status %0d last %0b",
                       addr, st, fin);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (addr !== want.entry_address) begin
                $error("entry_address: expected %h, got %h", want.entry_address, addr);
                errors++;
            end
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
            if (fin !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, fin);
                errors++;
            end
        endfunction
    endclass

    reloc_scoreboard sb;
    bit          calm;
    bit          hold_go;
    int unsigned items_sent;
    int unsigned ready_gap = 0;
    int unsigned cycles = 0;

    base_relocation_block_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .data_word     (data_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .entry_address (entry_address),
        .status        (status),
        .last          (last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** base_relocation_block_parser: FAILED **");
            $finish;
        end
    end

    // result side: random stall bursts, long hold on request
    always @(negedge clk)
    begin
        if (hold_go)
            out_ready <= 1'b0;
        else if (ready_gap != 0) begin
            out_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else if (!calm && $urandom_range(0, 9) == 0) begin
            out_ready <= 1'b0;
            ready_gap <= $urandom_range(0, 12);
        end
        else
            out_ready <= 1'b1;
    end

    // long receiver hold-off, counted here
    initial
    begin
        wait (hold_go);
        repeat (LONG_HOLD) @(negedge clk);
        hold_go = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.match_result(entry_address, status, last);
    end

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_item(opcode_t op, logic [15:0] w);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_word <= w;
        do @(posedge clk); while (!in_ready);
        sb.take_word(op, w);
        if (op != OP_NONE)
            items_sent++;
        @(negedge clk);
    endtask

    // APB write followed by a read-back
    task automatic cfg_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value) begin
            $error("prdata: expected %h, got %h", value, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop any parse, drain results, let the pipeline empty, then reprogram
    task automatic configure(logic [31:0] base, logic [31:0] bytes);
        if (sb.walk != WALK_IDLE)
            send_item(OP_EXHAUST, 16'($urandom));
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_write(REG_DIR_BASE, base);
        cfg_write(REG_DIR_BYTES, bytes);
    endtask

    // one directory walk: mostly well-formed blocks, else broken sizes and cuts
    task automatic run_parse(int unsigned max_words, bit tidy);
        logic [15:0] words[$];
        int unsigned bytes;
        int unsigned n;
        int unsigned cut;
        logic [31:0] pg;
        logic [31:0] sz;
        bytes = 0;
        while (bytes < sb.dir_bytes && words.size() < max_words) begin
            pg = $urandom;
            n  = $urandom_range(0, 8);
            sz = 8 + 2 * n;
            if (!tidy && $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: sz = $urandom_range(0, 8);
                    1: sz = $urandom;
                    2: sz = sz + 1;
                    default: sz = sz + 2 * $urandom_range(1, 4);
                endcase
            end
            words = {words, pg[15:0]};
            words = {words, pg[31:16]};
            words = {words, sz[15:0]};
            words = {words, sz[31:16]};
            repeat (n) begin
                if ($urandom_range(0, 4) == 0)
                    words = {words, {4'h0, 12'($urandom)}};
                else
                    words = {words, {4'($urandom_range(1, 15)), 12'($urandom)}};
            end
            bytes += 8 + 2 * n;
        end
        if (!tidy) begin
            cut = $urandom_range(0, words.size());
            while (words.size() > cut)
                void'(words.pop_back());
        end
        send_item(OP_START, 16'($urandom));
        foreach (words[i]) begin
            if ($urandom_range(0, 29) == 0)
                send_item(OP_NONE, 16'($urandom));
            if (!tidy && $urandom_range(0, 39) == 0)
                send_item($urandom_range(0, 1) ? OP_START : OP_EXHAUST, 16'($urandom));
            send_item(OP_DATA, words[i]);
        end
        if (sb.walk != WALK_IDLE && $urandom_range(0, 1) == 1)
            send_item(OP_EXHAUST, 16'($urandom));
    endtask

    // main sequence
    initial
    begin
        int unsigned phase_no;
        logic [31:0] b;
        logic [31:0] n;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        opcode     = OP_NONE;
        data_word  = '0;
        out_ready  = 1'b0;
        calm       = 1'b0;
        hold_go    = 1'b0;
        items_sent = 0;
        phase_no   = 0;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at reset: absent; idle words and unused opcode ignored
        send_item(OP_START, 16'h0000);
        send_item(OP_DATA, 16'hFFFF);
        send_item(OP_EXHAUST, 16'h0000);
        send_item(OP_NONE, 16'hFFFF);
        // one register zero: absent
        configure(32'h0000_0000, 32'h0000_0010);
        send_item(OP_START, 16'h0000);
        configure(32'h0000_1000, 32'h0000_0000);
        send_item(OP_START, 16'h0000);
        // end wraps below base: success at once
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_START, 16'hFFFF);
        // full walk: skipped entry, short block, max page and size, entry plus success
        configure(32'hFFFF_F000, 32'h0000_0020);
        send_item(OP_START, 16'h0000);
        send_item(OP_DATA, 16'hE000);
        send_item(OP_DATA, 16'hABCD);
        send_item(OP_DATA, 16'h000C);
        send_item(OP_DATA, 16'h0000);
        send_item(OP_DATA, 16'h3FFF);
        send_item(OP_NONE, 16'h0000);
        send_item(OP_DATA, 16'h0123);
        send_item(OP_DATA, 16'h1234);
        send_item(OP_DATA, 16'h5678);
        send_item(OP_DATA, 16'h0004);
        send_item(OP_DATA, 16'h0000);
        repeat (5) send_item(OP_DATA, 16'hFFFF);
        send_item(OP_DATA, 16'hF000);
        // restart mid-parse, then exhausted source
        send_item(OP_START, 16'h0000);
        send_item(OP_DATA, 16'h1111);
        send_item(OP_START, 16'h0000);
        send_item(OP_DATA, 16'h2222);
        send_item(OP_EXHAUST, 16'h0000);

        // random phases, each with its own register setting
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= CALM_AT)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0: begin b = 32'h0;                                  n = $urandom; end
                1: begin b = $urandom;                               n = 32'h0; end
                2: begin b = 32'hFFFF_FFFF - 32'($urandom_range(0, 64)); n = $urandom_range(1, 96); end
                3: begin b = $urandom;                               n = $urandom; end
                4: begin b = 32'hFFFF_FFFF;                          n = 32'hFFFF_FFFF; end
                default: begin b = $urandom;                         n = $urandom_range(1, 96); end
            endcase
            if (phase_no == 3) begin
                // long receiver hold-off over a dense directory
                configure(32'h0040_0000, 32'h0000_0100);
                hold_go = 1'b1;
                run_parse(130, 1'b1);
            end
            else begin
                configure(b, n);
                repeat ($urandom_range(1, 4))
                    run_parse(40, $urandom_range(0, 3) != 0);
            end
            phase_no++;
        end

        // drain
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("** base_relocation_block_parser: PASSED **");
        else
            $display("** base_relocation_block_parser: FAILED **");
        $finish;
    end

endmodule
